@@ design/ppst_pkg.sv @@
`default_nettype none

package ppst_pkg;

  localparam int unsigned DIM              = 6;
  localparam int unsigned MAT_SIZE         = 36;
  localparam int unsigned DEF_MAX_MATRICES = 16;
  localparam int unsigned DEF_MAX_VECTORS  = 16;
  localparam int unsigned CFG_IDX_W        = 3;

  localparam logic [1:0] CMD_LOAD_MAT = 2'd0;
  localparam logic [1:0] CMD_LOAD_VEC = 2'd1;
  localparam logic [1:0] CMD_XFORM    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_REF_GAMMA     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_REF_GAMMA = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAVENUMBER    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_WAVENUM   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLICE_RATIO   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_COUNT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VECTOR_COUNT  = 3'd6;

  localparam logic [31:0] RST_REF_GAMMA     = 32'h0001_0000;
  localparam logic [31:0] RST_INV_REF_GAMMA = 32'h8000_0000;
  localparam logic [31:0] RST_WAVENUMBER    = 32'h0001_0000;
  localparam logic [31:0] RST_INV_WAVENUM   = 32'h0001_0000;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_POS,
    OP_SEL,
    OP_NORM,
    OP_MAC,
    OP_BLEND,
    OP_DENORM,
    OP_VA,
    OP_VB,
    OP_VADD,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] j;
    logic [2:0] l;
    logic       side;
  } dp_cmd_t;

  typedef struct packed {
    logic mat_en;
    logic vec_en;
    logic out_free;
  } dp_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
    logic signed [31:0] r;
    if (v > 70'sd2147483647) begin
      r = 32'sh7fff_ffff;
    end else if (v < -70'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = $signed(v[31:0]);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/ppst_if.sv @@
`default_nettype none

interface ppst_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [9:0]         table_index;
  logic signed [31:0] coefficient;
  logic [15:0]        slice_index;
  logic signed [31:0] x_in;
  logic signed [31:0] px_in;
  logic signed [31:0] y_in;
  logic signed [31:0] py_in;
  logic signed [31:0] phase_in;
  logic signed [31:0] energy_in;

  modport source (
    output valid, command, table_index, coefficient, slice_index,
    output x_in, px_in, y_in, py_in, phase_in, energy_in,
    input  ready
  );
  modport sink (
    input  valid, command, table_index, coefficient, slice_index,
    input  x_in, px_in, y_in, py_in, phase_in, energy_in,
    output ready
  );
endinterface

interface ppst_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_out;
  logic signed [31:0] px_out;
  logic signed [31:0] y_out;
  logic signed [31:0] py_out;
  logic signed [31:0] phase_out;
  logic signed [31:0] energy_out;

  modport source (
    output valid, x_out, px_out, y_out, py_out, phase_out, energy_out,
    input  ready
  );
  modport sink (
    input  valid, x_out, px_out, y_out, py_out, phase_out, energy_out,
    output ready
  );
endinterface

interface ppst_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ design/ppst_ctrl.sv @@
`default_nettype none

module ppst_ctrl
  import ppst_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o,
  output logic          in_ready_o
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_POS    = 12'b0000_0000_0010,
    S_SEL    = 12'b0000_0000_0100,
    S_WAIT   = 12'b0000_0000_1000,
    S_NORM   = 12'b0000_0001_0000,
    S_MAC    = 12'b0000_0010_0000,
    S_BLEND  = 12'b0000_0100_0000,
    S_DENORM = 12'b0000_1000_0000,
    S_VA     = 12'b0001_0000_0000,
    S_VB     = 12'b0010_0000_0000,
    S_VADD   = 12'b0100_0000_0000,
    S_FIN    = 12'b1000_0000_0000
  } state_e;

  localparam logic [2:0] LAST = 3'(DIM - 1);

  state_e     state_q, state_d;
  logic [2:0] j_q, j_d, l_q, l_d;
  logic       side_q, side_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      j_q     <= '0;
      l_q     <= '0;
      side_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      j_q     <= j_d;
      l_q     <= l_d;
      side_q  <= side_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    j_d        = j_q;
    l_d        = l_q;
    side_d     = side_q;
    cmd_o      = '{op: OP_NOP, j: j_q, l: l_q, side: side_q};
    in_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_POS;
      end
      S_POS: begin
        cmd_o.op = OP_POS;
        state_d  = S_SEL;
      end
      S_SEL: begin
        cmd_o.op = OP_SEL;
        state_d  = S_WAIT;
      end
      S_WAIT: begin
        j_d    = '0;
        l_d    = '0;
        side_d = 1'b0;
        if (stat_i.mat_en) state_d = S_NORM;
        else if (stat_i.vec_en) state_d = S_VA;
        else state_d = S_FIN;
      end
      S_NORM: begin
        cmd_o.op = OP_NORM;
        if (j_q == LAST) begin
          j_d     = '0;
          state_d = S_MAC;
        end else begin
          j_d = j_q + 3'd1;
        end
      end
      S_MAC: begin
        cmd_o.op = OP_MAC;
        side_d   = !side_q;
        if (side_q) begin
          if (l_q == LAST) begin
            l_d     = '0;
            state_d = S_BLEND;
          end else begin
            l_d = l_q + 3'd1;
          end
        end
      end
      S_BLEND: begin
        cmd_o.op = OP_BLEND;
        if (j_q == LAST) begin
          j_d     = '0;
          state_d = S_DENORM;
        end else begin
          j_d     = j_q + 3'd1;
          state_d = S_MAC;
        end
      end
      S_DENORM: begin
        cmd_o.op = OP_DENORM;
        if (j_q == LAST) begin
          j_d     = '0;
          state_d = stat_i.vec_en ? S_VA : S_FIN;
        end else begin
          j_d = j_q + 3'd1;
        end
      end
      S_VA: begin
        cmd_o.op   = OP_VA;
        cmd_o.side = 1'b0;
        state_d    = S_VB;
      end
      S_VB: begin
        cmd_o.op   = OP_VB;
        cmd_o.side = 1'b1;
        state_d    = S_VADD;
      end
      S_VADD: begin
        cmd_o.op = OP_VADD;
        if (j_q == LAST) begin
          j_d     = '0;
          state_d = S_FIN;
        end else begin
          j_d     = j_q + 3'd1;
          state_d = S_VA;
        end
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_OUT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ design/ppst_dp.sv @@
`default_nettype none

module ppst_dp
  import ppst_pkg::*;
#(
  parameter int unsigned MAX_MATRICES = DEF_MAX_MATRICES,
  parameter int unsigned MAX_VECTORS  = DEF_MAX_VECTORS
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire dp_cmd_t              cmd_i,
  output dp_stat_t                  stat_o,
  input  wire logic                 in_fire_i,
  input  wire logic [1:0]           command_i,
  input  wire logic [9:0]           table_index_i,
  input  wire logic signed [31:0]   coefficient_i,
  input  wire logic [15:0]          slice_index_i,
  input  wire logic signed [31:0]   x_in_i,
  input  wire logic signed [31:0]   px_in_i,
  input  wire logic signed [31:0]   y_in_i,
  input  wire logic signed [31:0]   py_in_i,
  input  wire logic signed [31:0]   phase_in_i,
  input  wire logic signed [31:0]   energy_in_i,
  input  wire logic                 cfg_fire_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]          cfg_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic signed [31:0]        x_out_o,
  output logic signed [31:0]        px_out_o,
  output logic signed [31:0]        y_out_o,
  output logic signed [31:0]        py_out_o,
  output logic signed [31:0]        phase_out_o,
  output logic signed [31:0]        energy_out_o
);

  localparam int unsigned MDEPTH = MAX_MATRICES * MAT_SIZE;
  localparam int unsigned VDEPTH = MAX_VECTORS * DIM;
  localparam int unsigned MAW    = $clog2(MDEPTH);
  localparam int unsigned VAW    = $clog2(VDEPTH);
  localparam int unsigned MEW    = (MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1;
  localparam int unsigned VEW    = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [15:0] f;
  } pick_t;

  // configuration
  logic [31:0] gamma_q, inv_gamma_q, wave_q, inv_wave_q, ratio_q;
  logic [4:0]  mcount_q, vcount_q;
  logic [8:0]  nm, nv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q     <= RST_REF_GAMMA;
      inv_gamma_q <= RST_INV_REF_GAMMA;
      wave_q      <= RST_WAVENUMBER;
      inv_wave_q  <= RST_INV_WAVENUM;
      ratio_q     <= '0;
      mcount_q    <= '0;
      vcount_q    <= '0;
    end else if (cfg_fire_i) begin
      unique case (cfg_index_i)
        REG_REF_GAMMA:     gamma_q     <= cfg_data_i;
        REG_INV_REF_GAMMA: inv_gamma_q <= cfg_data_i;
        REG_WAVENUMBER:    wave_q      <= cfg_data_i;
        REG_INV_WAVENUM:   inv_wave_q  <= cfg_data_i;
        REG_SLICE_RATIO:   ratio_q     <= cfg_data_i;
        REG_MATRIX_COUNT:  mcount_q    <= cfg_data_i[4:0];
        REG_VECTOR_COUNT:  vcount_q    <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  assign nm = (9'(mcount_q) > 9'(MAX_MATRICES)) ? 9'(MAX_MATRICES) : 9'(mcount_q);
  assign nv = (9'(vcount_q) > 9'(MAX_VECTORS)) ? 9'(MAX_VECTORS) : 9'(vcount_q);

  logic out_valid_q;
  assign stat_o = '{mat_en: (nm != 9'd0), vec_en: (nv != 9'd0),
                    out_free: (!out_valid_q || out_ready_i)};

  // coefficient tables
  logic [31:0]        mtab [MDEPTH];
  logic [31:0]        vtab [VDEPTH];
  logic [31:0]        mrd_q, vrd_q;
  logic [31:0]        widx, maddr, vaddr;
  logic [MEW-1:0]     ma_q, mb_q;
  logic [VEW-1:0]     va_q, vb_q;
  logic               mwe, vwe;

  assign widx  = 32'(table_index_i);
  assign mwe   = in_fire_i && (command_i == CMD_LOAD_MAT) && (widx < 32'(MDEPTH));
  assign vwe   = in_fire_i && (command_i == CMD_LOAD_VEC) && (widx < 32'(VDEPTH));
  assign maddr = 32'(cmd_i.side ? mb_q : ma_q) * 32'(MAT_SIZE)
               + 32'(cmd_i.j) * 32'(DIM) + 32'(cmd_i.l);
  assign vaddr = 32'(cmd_i.side ? vb_q : va_q) * 32'(DIM) + 32'(cmd_i.j);

  always_ff @(posedge clk_i) begin
    if (mwe) mtab[widx[MAW-1:0]] <= coefficient_i;
    mrd_q <= mtab[maddr[MAW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (vwe) vtab[widx[VAW-1:0]] <= coefficient_i;
    vrd_q <= vtab[vaddr[VAW-1:0]];
  end

  // execute stage
  dp_cmd_t cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q <= '{op: OP_NOP, j: '0, l: '0, side: 1'b0};
    end else begin
      cmd_q <= cmd_i;
    end
  end

  logic signed [31:0] p_q  [DIM];
  logic signed [31:0] r0_q [DIM];
  logic signed [31:0] r1_q [DIM];
  logic signed [43:0] acc_a_q, acc_b_q;
  logic [47:0]        pos_q;
  logic [15:0]        slice_q;
  logic [15:0]        mf_q, vf_q;
  logic signed [31:0] vlo_q;
  logic signed [33:0] d_q;

  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mprod, rnd31, rnd24, rnd16;
  logic signed [44:0] bdiff;
  logic signed [61:0] bprod;
  logic signed [43:0] term;
  pick_t              mpick, vpick;

  function automatic pick_t pick(input logic [8:0] n, input logic [31:0] ratio,
                                 input logic [47:0] pos);
    pick_t       r;
    logic [31:0] kk, last;
    kk   = pos[47:16];
    last = 32'(n) - 32'd1;
    r    = '{a: '0, b: '0, f: '0};
    if (n > 9'd1 && ratio != 32'd0) begin
      if (kk >= last) begin
        r.a = last;
        r.b = last;
      end else begin
        r.a = kk;
        r.b = kk + 32'd1;
        r.f = pos[15:0];
      end
    end
    return r;
  endfunction

  assign mpick = pick(nm, ratio_q, pos_q);
  assign vpick = pick(nv, ratio_q, pos_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_q.op)
      OP_POS: begin
        mul_a = $signed({18'b0, slice_q});
        mul_b = $signed({2'b0, ratio_q});
      end
      OP_NORM: begin
        mul_a = 34'(p_q[cmd_q.j]);
        mul_b = (cmd_q.j == 3'd4) ? $signed({2'b0, inv_wave_q}) : $signed({2'b0, inv_gamma_q});
      end
      OP_MAC: begin
        mul_a = 34'($signed(mrd_q));
        mul_b = 34'(r0_q[cmd_q.l]);
      end
      OP_DENORM: begin
        mul_a = (cmd_q.j == 3'd5) ? 34'(sat32(70'(r1_q[5]) + 70'sd65536))
                                  : 34'(r1_q[cmd_q.j]);
        mul_b = (cmd_q.j == 3'd4) ? $signed({2'b0, wave_q}) : $signed({2'b0, gamma_q});
      end
      OP_VB: begin
        mul_a = 34'($signed(vrd_q)) - 34'(vlo_q);
        mul_b = $signed({18'b0, vf_q});
      end
      OP_VADD: begin
        mul_a = d_q;
        mul_b = (cmd_q.j == 3'd4) ? $signed({2'b0, wave_q}) : $signed({2'b0, gamma_q});
      end
      default: ;
    endcase
  end

  assign mprod = mul_a * mul_b;
  assign rnd31 = (mprod + 68'sd1073741824) >>> 31;
  assign rnd24 = (mprod + 68'sd8388608) >>> 24;
  assign rnd16 = (mprod + 68'sd32768) >>> 16;
  assign term  = 44'(rnd24);
  assign bdiff = 45'(acc_b_q) - 45'(acc_a_q);
  assign bprod = bdiff * $signed({1'b0, mf_q});

  always_ff @(posedge clk_i) begin
    case (cmd_q.op)
      OP_POS: pos_q <= mprod[47:0];
      OP_SEL: begin
        ma_q <= mpick.a[MEW-1:0];
        mb_q <= mpick.b[MEW-1:0];
        mf_q <= mpick.f;
        va_q <= vpick.a[VEW-1:0];
        vb_q <= vpick.b[VEW-1:0];
        vf_q <= vpick.f;
      end
      OP_NORM: begin
        case (cmd_q.j)
          3'd1, 3'd3: r0_q[cmd_q.j] <= sat32(70'(rnd31));
          3'd4:       r0_q[cmd_q.j] <= sat32(70'(rnd16));
          3'd5:       r0_q[cmd_q.j] <= sat32(70'(rnd31) - 70'sd65536);
          default:    r0_q[cmd_q.j] <= p_q[cmd_q.j];
        endcase
      end
      OP_MAC: begin
        if (cmd_q.side) acc_b_q <= (cmd_q.l == 3'd0) ? term : acc_b_q + term;
        else acc_a_q <= (cmd_q.l == 3'd0) ? term : acc_a_q + term;
      end
      OP_BLEND: begin
        r1_q[cmd_q.j] <= sat32(70'(acc_a_q) + 70'((bprod + 62'sd32768) >>> 16));
      end
      OP_DENORM: begin
        case (cmd_q.j)
          3'd0, 3'd2: p_q[cmd_q.j] <= r1_q[cmd_q.j];
          default:    p_q[cmd_q.j] <= sat32(70'(rnd16));
        endcase
      end
      OP_VA: vlo_q <= $signed(vrd_q);
      OP_VB: d_q <= 34'((mprod + (68'(vlo_q) <<< 16) + 68'sd8388608) >>> 24);
      OP_VADD: begin
        case (cmd_q.j)
          3'd0, 3'd2: p_q[cmd_q.j] <= sat32(70'(p_q[cmd_q.j]) + 70'(d_q));
          default:    p_q[cmd_q.j] <= sat32(70'(p_q[cmd_q.j]) + 70'(rnd16));
        endcase
      end
      OP_OUT: begin
        x_out_o      <= p_q[0];
        px_out_o     <= p_q[1];
        y_out_o      <= p_q[2];
        py_out_o     <= p_q[3];
        phase_out_o  <= p_q[4];
        energy_out_o <= p_q[5];
      end
      default: ;
    endcase
    if (in_fire_i && command_i == CMD_XFORM) begin
      slice_q <= slice_index_i;
      p_q[0]  <= x_in_i;
      p_q[1]  <= px_in_i;
      p_q[2]  <= y_in_i;
      p_q[3]  <= py_in_i;
      p_q[4]  <= phase_in_i;
      p_q[5]  <= energy_in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_q.op == OP_OUT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ design/particle_phase_space_transform.sv @@
// channel  dir  handshake        payload
// in_i     in   valid / ready    command, table_index, coefficient, slice_index, 6 coords
// out_o    out  valid / ready    x_out .. energy_out
// cfg_i    in   valid / ready    index, data (always ready)
// a load command writes its table entry when accepted; a transform runs position and
// selection, then the matrix steps with matrices enabled and the shift-vector steps with
// vectors enabled, paced by the shared multiplier and each table's one read port
// the result waits in an output register, so the next item is taken while it stalls
// rst_ni clears control and configuration; coefficient tables are not cleared
`default_nettype none

module particle_phase_space_transform
  import ppst_pkg::*;
#(
  parameter int unsigned MAX_MATRICES = DEF_MAX_MATRICES,
  parameter int unsigned MAX_VECTORS  = DEF_MAX_VECTORS
) (
  input wire logic    clk_i,
  input wire logic    rst_ni,
  ppst_in_if.sink     in_i,
  ppst_out_if.source  out_o,
  ppst_cfg_if.sink    cfg_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready, in_fire, start;

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;
  assign in_fire     = in_i.valid && in_ready;
  assign start       = in_fire && (in_i.command == CMD_XFORM);

  ppst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_ready_o (in_ready)
  );

  ppst_dp #(
    .MAX_MATRICES (MAX_MATRICES),
    .MAX_VECTORS  (MAX_VECTORS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .in_fire_i     (in_fire),
    .command_i     (in_i.command),
    .table_index_i (in_i.table_index),
    .coefficient_i (in_i.coefficient),
    .slice_index_i (in_i.slice_index),
    .x_in_i        (in_i.x_in),
    .px_in_i       (in_i.px_in),
    .y_in_i        (in_i.y_in),
    .py_in_i       (in_i.py_in),
    .phase_in_i    (in_i.phase_in),
    .energy_in_i   (in_i.energy_in),
    .cfg_fire_i    (cfg_i.valid),
    .cfg_index_i   (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .x_out_o       (out_o.x_out),
    .px_out_o      (out_o.px_out),
    .y_out_o       (out_o.y_out),
    .py_out_o      (out_o.py_out),
    .phase_out_o   (out_o.phase_out),
    .energy_out_o  (out_o.energy_out)
  );

endmodule

`default_nettype wire

@@ design/ppst_checker.sv @@
`default_nettype none

module ppst_checker
  import ppst_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic [1:0]  in_command_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [31:0] out_x_i
);

  // result held under stall
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_x_i))
    else $error("result changed while stalled");

  // a transform item closes the input until its result is issued
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_command_i == CMD_XFORM |=> !in_ready_i)
    else $error("input open during transform");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i, 2))
    else $error("result without a transform in flight");

endmodule

bind particle_phase_space_transform ppst_checker u_ppst_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_command_i (in_i.command),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_x_i      (out_o.x_out)
);

`default_nettype wire

@@ tb/sv/tb.sv @@
module tb;
  import ppst_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  ppst_in_if  in_bus();
  ppst_out_if out_bus();
  ppst_cfg_if cfg_bus();

  particle_phase_space_transform uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_bus.sink), .out_o(out_bus.source),
    .cfg_i(cfg_bus.sink)
  );

  typedef struct packed {
    logic [1:0]         command;
    logic [9:0]         table_index;
    logic signed [31:0] coefficient;
    logic [15:0]        slice_index;
    logic signed [31:0] x, px, y, py, ph, en;
  } particle_cmd_t;

  typedef struct packed {
    logic signed [31:0] x, px, y, py, ph, en;
  } coords_t;

  localparam int NM = DEF_MAX_MATRICES;
  localparam int NV = DEF_MAX_VECTORS;

  longint mat_coef [NM*MAT_SIZE];
  longint vec_coef [NV*DIM];
  longint m_gamma, m_inv_gamma, m_k, m_inv_k, m_ratio, m_mcount, m_vcount;

  particle_cmd_t pending_items[$];
  coords_t       expected_coords[$];
  int  errors = 0;
  int  idle_pct = 28;
  bit  hold_sink = 0;
  int  hold_cycles = 0;

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rshift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic void pick(longint n, longint slice, output longint a, output longint b,
                               output longint wa, output longint wb);
    longint pos, k;
    a = 0; b = 0; wa = 65536; wb = 0;
    if (n > 1 && m_ratio != 0) begin
      pos = slice * m_ratio;
      k = pos >>> 16;
      if (k >= n - 1) begin
        a = n - 1; b = n - 1;
      end else begin
        a = k; b = k + 1; wb = pos & 16'hffff; wa = 65536 - wb;
      end
    end
  endfunction

  function automatic longint rnd_mul16(longint v, longint f);
    longint p;
    p = v * f;
    return rshift(p, 16);
  endfunction

  function automatic coords_t transform_particle(particle_cmd_t c);
    longint p [6];
    longint r0 [6];
    longint r1 [6];
    longint d [6];
    longint nm, nv, a, b, wa, wb, sa, sb;
    coords_t r;
    p[0] = c.x; p[1] = c.px; p[2] = c.y; p[3] = c.py; p[4] = c.ph; p[5] = c.en;
    nm = m_mcount > NM ? NM : m_mcount;
    nv = m_vcount > NV ? NV : m_vcount;
    if (nm > 0) begin
      r0[0] = p[0];
      r0[1] = clamp32(rshift(p[1] * m_inv_gamma, 31));
      r0[2] = p[2];
      r0[3] = clamp32(rshift(p[3] * m_inv_gamma, 31));
      r0[4] = clamp32(rnd_mul16(p[4], m_inv_k));
      r0[5] = clamp32(rshift(p[5] * m_inv_gamma, 31) - 65536);
      pick(nm, c.slice_index, a, b, wa, wb);
      for (int j = 0; j < 6; j++) begin
        sa = 0; sb = 0;
        for (int l = 0; l < 6; l++) begin
          sa += rshift(mat_coef[a*MAT_SIZE + j*6 + l] * r0[l], 24);
          sb += rshift(mat_coef[b*MAT_SIZE + j*6 + l] * r0[l], 24);
        end
        r1[j] = clamp32(rshift(sa * wa + sb * wb, 16));
      end
      p[0] = r1[0];
      p[1] = clamp32(rnd_mul16(r1[1], m_gamma));
      p[2] = r1[2];
      p[3] = clamp32(rnd_mul16(r1[3], m_gamma));
      p[4] = clamp32(rnd_mul16(r1[4], m_k));
      p[5] = clamp32(rnd_mul16(clamp32(65536 + r1[5]), m_gamma));
    end
    if (nv > 0) begin
      pick(nv, c.slice_index, a, b, wa, wb);
      for (int j = 0; j < 6; j++)
        d[j] = rshift(vec_coef[a*DIM + j] * wa + vec_coef[b*DIM + j] * wb, 24);
      p[0] = clamp32(p[0] + d[0]);
      p[1] = clamp32(p[1] + rnd_mul16(d[1], m_gamma));
      p[2] = clamp32(p[2] + d[2]);
      p[3] = clamp32(p[3] + rnd_mul16(d[3], m_gamma));
      p[4] = clamp32(p[4] + rnd_mul16(d[4], m_k));
      p[5] = clamp32(p[5] + rnd_mul16(d[5], m_gamma));
    end
    r.x = p[0]; r.px = p[1]; r.y = p[2]; r.py = p[3]; r.ph = p[4]; r.en = p[5];
    return r;
  endfunction

  function automatic void apply_item(particle_cmd_t c);
    if (c.command == CMD_LOAD_MAT) begin
      if (c.table_index < NM*MAT_SIZE) mat_coef[c.table_index] = c.coefficient;
    end else if (c.command == CMD_LOAD_VEC) begin
      if (c.table_index < NV*DIM) vec_coef[c.table_index] = c.coefficient;
    end else if (c.command == CMD_XFORM) begin
      expected_coords.push_back(transform_particle(c));
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) apply_item(pending_items.pop_front());
      if ((!in_bus.valid || in_bus.ready)) begin
        if (pending_items.size() > (in_bus.valid && in_bus.ready ? 0 : 0) &&
            $urandom_range(99) >= idle_pct) begin
          in_bus.valid       <= 1'b1;
          in_bus.command     <= pending_items[0].command;
          in_bus.table_index <= pending_items[0].table_index;
          in_bus.coefficient <= pending_items[0].coefficient;
          in_bus.slice_index <= pending_items[0].slice_index;
          in_bus.x_in        <= pending_items[0].x;
          in_bus.px_in       <= pending_items[0].px;
          in_bus.y_in        <= pending_items[0].y;
          in_bus.py_in       <= pending_items[0].py;
          in_bus.phase_in    <= pending_items[0].ph;
          in_bus.energy_in   <= pending_items[0].en;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    coords_t w;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_coords.size() == 0) begin
          $display("result with nothing expected");
          errors++;
        end else begin
          w = expected_coords.pop_front();
          if (out_bus.x_out !== w.x) report_mismatch("x", out_bus.x_out, w.x);
          if (out_bus.px_out !== w.px) report_mismatch("px", out_bus.px_out, w.px);
          if (out_bus.y_out !== w.y) report_mismatch("y", out_bus.y_out, w.y);
          if (out_bus.py_out !== w.py) report_mismatch("py", out_bus.py_out, w.py);
          if (out_bus.phase_out !== w.ph) report_mismatch("phase", out_bus.phase_out, w.ph);
          if (out_bus.energy_out !== w.en) report_mismatch("energy", out_bus.energy_out, w.en);
        end
      end
      if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
      out_bus.ready <= !(hold_sink || hold_cycles > 1) && ($urandom_range(99) >= idle_pct);
    end
  end

  // in the driver loop, pop happens at the accept edge; the payload of item 0 is re-driven
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk_i); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    case (idx)
      REG_REF_GAMMA:     m_gamma = val;
      REG_INV_REF_GAMMA: m_inv_gamma = val;
      REG_WAVENUMBER:    m_k = val;
      REG_INV_WAVENUM:   m_inv_k = val;
      REG_SLICE_RATIO:   m_ratio = val;
      REG_MATRIX_COUNT:  m_mcount = val[4:0];
      REG_VECTOR_COUNT:  m_vcount = val[4:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || in_bus.valid || expected_coords.size() != 0)
      @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  function automatic particle_cmd_t load_item(logic [1:0] cmd, int idx, logic [31:0] v);
    particle_cmd_t c;
    c = '0;
    c.command = cmd; c.table_index = idx; c.coefficient = v;
    c.slice_index = $urandom; c.x = $urandom;
    return c;
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(7))
      0: return 32'h0100_0000;
      1: return {$urandom} | 32'h8000_0000;
      2: return $urandom;
      default: return $signed($urandom_range(33554432)) - 32'sd16777216;
    endcase
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom;
      default: return $signed($urandom_range(1 << 22)) - 32'sd2097152;
    endcase
  endfunction

  function automatic particle_cmd_t xform_item(int maxslice);
    particle_cmd_t c;
    c.command = CMD_XFORM;
    c.table_index = $urandom;
    c.coefficient = $urandom;
    c.slice_index = ($urandom_range(9) == 0) ? $urandom : $urandom_range(maxslice);
    c.x = rand_coord(); c.px = rand_coord(); c.y = rand_coord();
    c.py = rand_coord(); c.ph = rand_coord(); c.en = rand_coord();
    return c;
  endfunction

  task automatic fill_tables();
    for (int i = 0; i < NM*MAT_SIZE; i++) pending_items.push_back(load_item(CMD_LOAD_MAT, i,
      rand_coef()));
    for (int i = 0; i < NV*DIM; i++) pending_items.push_back(load_item(CMD_LOAD_VEC, i,
      rand_coef()));
    pending_items.push_back(load_item(CMD_LOAD_MAT, 576 + $urandom_range(447), $urandom));
    pending_items.push_back(load_item(CMD_LOAD_VEC, 96 + $urandom_range(927), $urandom));
    pending_items.push_back(load_item(2'd3, $urandom, $urandom));
    drain();
  endtask

  initial begin
    particle_cmd_t c;
    cfg_bus.valid = 1'b0; cfg_bus.index = '0; cfg_bus.data = '0;
    in_bus.valid = 1'b0; in_bus.command = '0; in_bus.table_index = '0;
    in_bus.coefficient = '0; in_bus.slice_index = '0; in_bus.x_in = '0;
    in_bus.px_in = '0; in_bus.y_in = '0; in_bus.py_in = '0;
    in_bus.phase_in = '0; in_bus.energy_in = '0; out_bus.ready = 1'b0;
    m_gamma = RST_REF_GAMMA; m_inv_gamma = RST_INV_REF_GAMMA; m_k = RST_WAVENUMBER;
    m_inv_k = RST_INV_WAVENUM; m_ratio = 0; m_mcount = 0; m_vcount = 0;
    foreach (mat_coef[i]) mat_coef[i] = 0;
    foreach (vec_coef[i]) vec_coef[i] = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // counts zero: pass-through
    c = xform_item(100); c.x = 32'h7fff_ffff; c.px = 32'h8000_0000;
    pending_items.push_back(c);
    c = xform_item(100); c.x = 0; c.en = 0;
    pending_items.push_back(c);
    fill_tables();

    // single entries, default scaling
    write_reg(REG_MATRIX_COUNT, 1);
    write_reg(REG_VECTOR_COUNT, 1);
    for (int i = 0; i < 6; i++) pending_items.push_back(xform_item(65535));
    c = xform_item(0); c.x = 32'h7fff_ffff; c.px = 32'h7fff_ffff; c.y = 32'h8000_0000;
    c.py = 32'h8000_0000; c.ph = 32'h7fff_ffff; c.en = 32'h8000_0000;
    pending_items.push_back(c);
    drain();

    // interpolation with clamp at the last entry
    write_reg(REG_SLICE_RATIO, 32'h0000_4000);
    write_reg(REG_MATRIX_COUNT, 16);
    write_reg(REG_VECTOR_COUNT, 31);
    for (int i = 0; i < 6; i++) pending_items.push_back(xform_item(80));
    c = xform_item(0); c.slice_index = 16'hffff; pending_items.push_back(c);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin
          write_reg(REG_REF_GAMMA, $urandom_range(32'h0040_0000, 32'h0000_8000));
          write_reg(REG_INV_REF_GAMMA, $urandom_range(32'h8000_0000));
          write_reg(REG_WAVENUMBER, $urandom_range(32'h0010_0000));
          write_reg(REG_INV_WAVENUM, $urandom_range(32'h0010_0000));
        end
        1: begin
          write_reg(REG_REF_GAMMA, 32'hffff_ffff);
          write_reg(REG_INV_REF_GAMMA, 0);
          write_reg(REG_WAVENUMBER, 32'hffff_ffff);
          write_reg(REG_INV_WAVENUM, 32'hffff_ffff);
        end
        2: begin
          write_reg(REG_REF_GAMMA, 0);
          write_reg(REG_INV_REF_GAMMA, 32'h8000_0000);
          write_reg(REG_WAVENUMBER, 0);
          write_reg(REG_INV_WAVENUM, 0);
        end
        default: begin
          write_reg(REG_REF_GAMMA, $urandom);
          write_reg(REG_INV_REF_GAMMA, $urandom_range(32'h8000_0000));
          write_reg(REG_WAVENUMBER, $urandom);
          write_reg(REG_INV_WAVENUM, $urandom);
        end
      endcase
      write_reg(REG_SLICE_RATIO, (ph == 5) ? 32'hffff_ffff : $urandom_range(32'h0002_0000));
      write_reg(REG_MATRIX_COUNT, $urandom_range(31));
      write_reg(REG_VECTOR_COUNT, $urandom_range(31));
      idle_pct = (ph == 3) ? 0 : 28;
      if (ph == 2) begin
        hold_cycles <= 400;
      end
      for (int i = 0; i < 125; i++) begin
        if ($urandom_range(19) == 0)
          pending_items.push_back(load_item($urandom_range(1), $urandom_range(1023), $urandom));
        else
          pending_items.push_back(xform_item(40));
      end
      if (ph == 6) begin
        pending_items.push_back(load_item(2'd3, $urandom, $urandom));
        // table contents changed by random loads above are tracked by the predictor
      end
      drain();
    end

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
